// ===== rtl/core/tees_pkg.sv =====
// shared types, field widths and codes for the timed edf event scheduler
// no dependencies
`timescale 1ns / 1ps

package tees_pkg;

  localparam int TASK_W            = 8;
  localparam int TICK_W            = 32;
  localparam int LEVEL_W           = 32;
  localparam int SLOT_FIELD_W      = 4;
  localparam int DEFAULT_POOL_SIZE = 16;

  localparam logic [1:0] ACT_CREATE  = 2'd0;
  localparam logic [1:0] ACT_TRANSIT = 2'd1;
  localparam logic [1:0] ACT_RECEIVE = 2'd2;
  localparam logic [1:0] ACT_DELETE  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_IDLE  = 2'd1;
  localparam logic [1:0] ST_NO_EXEC  = 2'd2;
  localparam logic [1:0] ST_NO_MATCH = 2'd3;

  localparam logic [1:0] PLACE_IDLE  = 2'd0;
  localparam logic [1:0] PLACE_SCHED = 2'd1;
  localparam logic [1:0] PLACE_READY = 2'd2;
  localparam logic [1:0] PLACE_HELD  = 2'd3;

  typedef enum logic [3:0] {
    OP_CREATE  = 4'b0001,
    OP_TRANSIT = 4'b0010,
    OP_RECEIVE = 4'b0100,
    OP_DELETE  = 4'b1000
  } op_t;

  typedef struct packed {
    logic [1:0]              action;
    logic [TASK_W-1:0]       source_task;
    logic [TASK_W-1:0]       target_task;
    logic [TICK_W-1:0]       next_deadline;
    logic [TICK_W-1:0]       proc_time;
    logic                    is_last;
    logic [TICK_W-1:0]       now_tick;
    logic [SLOT_FIELD_W-1:0] slot_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [SLOT_FIELD_W-1:0] slot_out;
    logic [TASK_W-1:0]       ev_source;
    logic [TASK_W-1:0]       ev_target;
    logic [TICK_W-1:0]       ev_deadline;
    logic [TICK_W-1:0]       ev_release;
    logic [LEVEL_W-1:0]      ev_level;
  } out_item_t;

  typedef struct packed {
    logic [TASK_W-1:0]  src;
    logic [TASK_W-1:0]  dst;
    logic [TICK_W-1:0]  deadline;
    logic [TICK_W-1:0]  release_tick;
    logic [LEVEL_W-1:0] level;
  } stamp_t;

  typedef struct packed {
    op_t                     op;
    logic [TASK_W-1:0]       src;
    logic [TASK_W-1:0]       dst;
    logic [TICK_W-1:0]       deadline;
    logic [TICK_W-1:0]       release_tick;
    logic [TICK_W-1:0]       now_tick;
    logic [SLOT_FIELD_W-1:0] slot_in;
    logic                    slot_ok;
  } cmd_t;

  function automatic out_item_t mk_res(logic [1:0] status, logic [SLOT_FIELD_W-1:0] slot,
                                       stamp_t st);
    out_item_t r;
    r.status      = status;
    r.slot_out    = slot;
    r.ev_source   = st.src;
    r.ev_target   = st.dst;
    r.ev_deadline = st.deadline;
    r.ev_release  = st.release_tick;
    r.ev_level    = st.level;
    return r;
  endfunction

endpackage

// ===== rtl/core/tees_front.sv =====
// front end: takes requests, classifies them and holds them in a two-entry queue
// depends on tees_pkg
`timescale 1ns / 1ps

module tees_front #(
  parameter int POOL_SIZE = tees_pkg::DEFAULT_POOL_SIZE
) (
  input  logic              clk,
  input  logic              rst,
  input  tees_pkg::in_item_t cmd,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  output tees_pkg::cmd_t    q_cmd,
  output logic              q_valid,
  input  logic              q_pop
);
  import tees_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       dec;
  logic       push;

  always_comb begin
    case (cmd.action)
      ACT_CREATE:  dec.op = OP_CREATE;
      ACT_TRANSIT: dec.op = OP_TRANSIT;
      ACT_RECEIVE: dec.op = OP_RECEIVE;
      default:     dec.op = OP_DELETE;
    endcase
    dec.src          = cmd.source_task;
    dec.dst          = cmd.target_task;
    dec.deadline     = cmd.next_deadline;
    dec.release_tick = cmd.is_last ? cmd.next_deadline : cmd.proc_time;
    dec.now_tick     = cmd.now_tick;
    dec.slot_in      = cmd.slot_in;
    dec.slot_ok      = 32'(cmd.slot_in) < 32'(POOL_SIZE);
  end

  assign cmd_stall = (count == 2'd2);
  assign push      = cmd_valid && !cmd_stall;
  assign q_valid   = (count != 2'd0);
  assign q_cmd     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== rtl/core/tees_engine.sv =====
// back end: slot stamp memory, idle and ready lists, pool scans and result register
// depends on tees_pkg
`timescale 1ns / 1ps

module tees_engine #(
  parameter int POOL_SIZE = tees_pkg::DEFAULT_POOL_SIZE
) (
  input  logic                clk,
  input  logic                rst,
  input  tees_pkg::cmd_t      q_cmd,
  input  logic                q_valid,
  output logic                q_pop,
  output tees_pkg::out_item_t res,
  output logic                res_valid,
  input  logic                res_stall
);
  import tees_pkg::*;

  localparam int SW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CW = $clog2(POOL_SIZE + 1);
  localparam logic [CW-1:0] FULL     = CW'(POOL_SIZE);
  localparam logic [SW-1:0] LAST_IDX = SW'(POOL_SIZE - 1);

  typedef logic [POOL_SIZE-1:0][SW-1:0] list_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_TRD  = 7'b0000010,
    S_TEV  = 7'b0000100,
    S_RRD  = 7'b0001000,
    S_REV  = 7'b0010000,
    S_DRD  = 7'b0100000,
    S_DEV  = 7'b1000000
  } state_t;

  function automatic list_t drop(list_t l, logic [CW-1:0] pos);
    list_t o;
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < POOL_SIZE - 1 && CW'(i) >= pos) begin
        o[i] = l[i + 1];
      end else begin
        o[i] = l[i];
      end
    end
    return o;
  endfunction

  function automatic logic [CW-1:0] find(list_t l, logic [CW-1:0] n, logic [SW-1:0] v);
    logic [CW-1:0] p;
    p = '0;
    for (int i = POOL_SIZE - 1; i >= 0; i--) begin
      if (CW'(i) < n && l[i] == v) begin
        p = CW'(i);
      end
    end
    return p;
  endfunction

  state_t             state;
  stamp_t             mem [POOL_SIZE];
  stamp_t             rdata;
  stamp_t             wdata;
  logic [SW-1:0]      rd_addr;
  logic [SW-1:0]      wr_addr;
  logic               mem_we;
  logic [1:0]         place [POOL_SIZE];
  logic [POOL_SIZE-1:0] in_exec;
  list_t              idle_list;
  list_t              ready_list;
  logic [CW-1:0]      idle_n;
  logic [CW-1:0]      ready_n;
  logic [LEVEL_W-1:0] serial;
  cmd_t               cur;
  logic [SW-1:0]      cur_slot;
  logic [SW-1:0]      idx;
  logic [SW-1:0]      rslot;
  logic [SW-1:0]      best_slot;
  stamp_t             best;
  logic               found;

  logic               moved;
  logic               take;
  logic [SW-1:0]      fin_slot;
  stamp_t             fin;
  list_t              idle_app;
  logic [CW-1:0]      idle_base;
  list_t              ready_del;
  logic               rx_match;
  logic [POOL_SIZE-1:0] idle_mask;
  logic [POOL_SIZE-1:0] ready_mask;
  logic [POOL_SIZE-1:0] sched_mask;

  assign q_pop    = (state == S_IDLE) && q_valid && !res_valid;
  assign cur_slot = SW'(cur.slot_in);
  assign mem_we   = q_pop && (q_cmd.op == OP_CREATE) && (idle_n != '0);
  assign wr_addr  = idle_list[0];

  always_comb begin
    wdata.src          = q_cmd.src;
    wdata.dst          = q_cmd.dst;
    wdata.deadline     = q_cmd.deadline;
    wdata.release_tick = q_cmd.release_tick;
    wdata.level        = serial;
  end

  always_comb begin
    case (state)
      S_TRD:   rd_addr = idx;
      S_RRD:   rd_addr = ready_list[idx];
      S_DRD:   rd_addr = cur_slot;
      default: rd_addr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  // transit scan: move due events to executable, track the earliest deadline
  always_comb begin
    moved = (place[idx] == PLACE_SCHED) && (in_exec[idx] || (rdata.release_tick <= cur.now_tick));
    take  = moved && (!found || ({rdata.deadline, rdata.release_tick, rdata.level} <
                                 {best.deadline, best.release_tick, best.level}));
    fin_slot = take ? idx : best_slot;
    fin      = take ? rdata : best;
  end

  assign rx_match = (rdata.src == cur.src) && (rdata.dst == cur.dst);

  // delete: unlink from its list and append to the idle tail
  always_comb begin
    if (place[cur_slot] == PLACE_IDLE) begin
      idle_app  = drop(idle_list, find(idle_list, idle_n, cur_slot));
      idle_base = idle_n - CW'(1);
    end else begin
      idle_app  = idle_list;
      idle_base = idle_n;
    end
    idle_app[idle_base[SW-1:0]] = cur_slot;
    ready_del = drop(ready_list, find(ready_list, ready_n, cur_slot));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      idle_n    <= FULL;
      ready_n   <= '0;
      serial    <= '0;
      in_exec   <= '0;
      found     <= 1'b0;
      for (int i = 0; i < POOL_SIZE; i++) begin
        place[i]     <= PLACE_IDLE;
        idle_list[i] <= SW'(i);
      end
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            cur <= q_cmd;
            case (q_cmd.op)
              OP_CREATE: begin
                res_valid <= 1'b1;
                if (idle_n == '0) begin
                  res <= mk_res(ST_NO_IDLE, '0, '0);
                end else begin
                  idle_list        <= drop(idle_list, '0);
                  idle_n           <= idle_n - CW'(1);
                  place[wr_addr]   <= PLACE_SCHED;
                  in_exec[wr_addr] <= 1'b0;
                  serial           <= serial + LEVEL_W'(1);
                  res <= mk_res(ST_OK, SLOT_FIELD_W'(wr_addr), wdata);
                end
              end
              OP_TRANSIT: begin
                idx   <= '0;
                found <= 1'b0;
                state <= S_TRD;
              end
              OP_RECEIVE: begin
                if (ready_n == '0) begin
                  res_valid <= 1'b1;
                  res       <= mk_res(ST_NO_MATCH, '0, '0);
                end else begin
                  idx   <= '0;
                  state <= S_RRD;
                end
              end
              OP_DELETE: begin
                if (!q_cmd.slot_ok) begin
                  res_valid <= 1'b1;
                  res       <= mk_res(ST_OK, '0, '0);
                end else begin
                  state <= S_DRD;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_TRD: state <= S_TEV;
        S_TEV: begin
          if (moved) begin
            in_exec[idx] <= 1'b1;
          end
          if (take) begin
            best      <= rdata;
            best_slot <= idx;
            found     <= 1'b1;
          end
          if (idx == LAST_IDX) begin
            state     <= S_IDLE;
            res_valid <= 1'b1;
            if (found || moved) begin
              in_exec[fin_slot]             <= 1'b0;
              place[fin_slot]               <= PLACE_READY;
              ready_list[ready_n[SW-1:0]]   <= fin_slot;
              ready_n                       <= ready_n + CW'(1);
              res <= mk_res(ST_OK, SLOT_FIELD_W'(fin_slot), fin);
            end else begin
              res <= mk_res(ST_NO_EXEC, '0, '0);
            end
          end else begin
            idx   <= idx + SW'(1);
            state <= S_TRD;
          end
        end
        S_RRD: begin
          rslot <= ready_list[idx];
          state <= S_REV;
        end
        S_REV: begin
          if (rx_match) begin
            ready_list   <= drop(ready_list, CW'(idx));
            ready_n      <= ready_n - CW'(1);
            place[rslot] <= PLACE_HELD;
            res_valid    <= 1'b1;
            res          <= mk_res(ST_OK, SLOT_FIELD_W'(rslot), rdata);
            state        <= S_IDLE;
          end else if (CW'(idx) + CW'(1) == ready_n) begin
            res_valid <= 1'b1;
            res       <= mk_res(ST_NO_MATCH, '0, '0);
            state     <= S_IDLE;
          end else begin
            idx   <= idx + SW'(1);
            state <= S_RRD;
          end
        end
        S_DRD: state <= S_DEV;
        S_DEV: begin
          if (place[cur_slot] == PLACE_READY) begin
            ready_list <= ready_del;
            ready_n    <= ready_n - CW'(1);
          end
          idle_list         <= idle_app;
          idle_n            <= idle_base + CW'(1);
          place[cur_slot]   <= PLACE_IDLE;
          in_exec[cur_slot] <= 1'b0;
          res_valid         <= 1'b1;
          res               <= mk_res(ST_OK, SLOT_FIELD_W'(cur_slot), rdata);
          state             <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      idle_mask[i]  = (place[i] == PLACE_IDLE);
      ready_mask[i] = (place[i] == PLACE_READY);
      sched_mask[i] = (place[i] == PLACE_SCHED);
    end
  end

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    $countones(idle_mask) == int'(idle_n))
    else $error("idle list length disagrees with slot places");

  a_ready_count: assert property (@(posedge clk) disable iff (rst)
    $countones(ready_mask) == int'(ready_n))
    else $error("ready list length disagrees with slot places");

  a_exec_sched: assert property (@(posedge clk) disable iff (rst)
    (in_exec & ~sched_mask) == '0)
    else $error("executable flag on a slot that is not scheduled");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (state == S_IDLE))
    else $error("engine busy while a result waits");

endmodule

// ===== rtl/core/timed_edf_event_scheduler.sv =====
// Timed earliest-deadline-first event scheduler over a fixed pool of event slots.
// Requests enter on cmd (cmd_valid / cmd_stall) and every request gives exactly
// one result on res (res_valid / res_stall); a request is taken at a clock edge
// with valid high and stall low.
// The front end queues up to two requests, so cmd_stall only rises when both
// queue entries are full. The back end works on one request at a time:
//   create, or delete of a slot out of range: result straight from the idle state
//   delete: one stamp memory read
//   transit: one stamp memory read per slot over the whole pool
//   receive: one stamp memory read per ready entry (ready list walk, stops at a match)
// The stamp memory has a single read port, so the scans read one slot at a time.
// Results sit in an output register; while res_stall is high the result holds
// and the back end takes no new request, the queue still fills.
// Synchronous reset puts all slots idle in order 0 upwards, empties the ready
// list, clears the serial counter and both handshakes; no clearing pass.
// Depends on tees_pkg, tees_front, tees_engine.
`timescale 1ns / 1ps

module timed_edf_event_scheduler #(
  parameter int POOL_SIZE = tees_pkg::DEFAULT_POOL_SIZE
) (
  input  logic                clk,
  input  logic                rst,
  input  tees_pkg::in_item_t  cmd,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  output tees_pkg::out_item_t res,
  output logic                res_valid,
  input  logic                res_stall
);
  import tees_pkg::*;

  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;

  tees_front #(.POOL_SIZE(POOL_SIZE)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .q_cmd     (q_cmd),
    .q_valid   (q_valid),
    .q_pop     (q_pop)
  );

  tees_engine #(.POOL_SIZE(POOL_SIZE)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_cmd     (q_cmd),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_stall (res_stall)
  );

endmodule
